### design/bfa_pkg.sv
package bfa_pkg;

    localparam int HEAP_BYTES_DEF    = 128;
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int HEADER_BYTES_DEF  = 4;

    localparam int ADDR_W   = 8;
    localparam int SIZE_W   = 8;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } t_func;

    typedef struct packed {
        logic capture;
        logic scan;
        logic alloc_commit;
        logic free_rd;
        logic free_commit;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
    } t_sts;

endpackage

### design/bfa_if.sv
interface bfa_req_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [bfa_pkg::SIZE_W-1:0]  request_size;
    logic [bfa_pkg::ADDR_W-1:0]  block_address;

    modport source (output valid, output func, output request_size,
                    output block_address, input ready);
    modport sink   (input valid, input func, input request_size,
                    input block_address, output ready);
endinterface

interface bfa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bfa_pkg::ADDR_W-1:0]   user_address;
    logic [bfa_pkg::STATUS_W-1:0] status;

    modport source (output valid, output user_address, output status, input ready);
    modport sink   (input valid, input user_address, input status, output ready);
endinterface

### design/best_fit_block_allocator.sv
// Best-fit allocator over a byte heap of HEAP_BYTES bytes, with up to TABLE_ENTRIES free
// extents and a HEADER_BYTES header in front of each block. One request is handled at a
// time and gives one response. An allocate reads the extent table one entry per cycle
// through its single read port, scanning every extent held before it commits; a free
// reads the block's header and then adds the block as a new extent. A request is
// taken again as soon as the last one has finished, even while its response still waits;
// a finished request stalls only if the previous response has not been taken. No
// clearing pass is needed after reset.
module best_fit_block_allocator #(
    parameter int HEAP_BYTES    = bfa_pkg::HEAP_BYTES_DEF,
    parameter int TABLE_ENTRIES = bfa_pkg::TABLE_ENTRIES_DEF,
    parameter int HEADER_BYTES  = bfa_pkg::HEADER_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfa_req_if.sink    i_req,
    bfa_rsp_if.source  o_rsp
);
    import bfa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_func  (i_req.func),
        .o_req_ready (i_req.ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bfa_datapath #(
        .HEAP_BYTES    (HEAP_BYTES),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .HEADER_BYTES  (HEADER_BYTES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_request_size  (i_req.request_size),
        .i_block_address (i_req.block_address),
        .o_user_address  (o_rsp.user_address),
        .o_status        (o_rsp.status)
    );

endmodule

### design/bfa_ram.sv
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/bfa_ctrl.sv
module bfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_func,
    output logic          o_req_ready,
    input  logic          i_rsp_ready,
    output logic          o_rsp_valid,
    input  bfa_pkg::t_sts i_sts,
    output bfa_pkg::t_cmd o_cmd
);
    import bfa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ALLOC_WR,
        S_FREE_RD,
        S_FREE_WR
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_rsp_valid;
    logic   n_rsp_valid;
    logic   out_free;

    assign out_free = !r_rsp_valid || i_rsp_ready;

    always_comb begin
        o_cmd              = '0;
        o_cmd.capture      = (r_state == S_IDLE) && i_req_valid;
        o_cmd.scan         = (r_state == S_SCAN);
        o_cmd.free_rd      = (r_state == S_FREE_RD);
        o_cmd.alloc_commit = (r_state == S_ALLOC_WR) && out_free;
        o_cmd.free_commit  = (r_state == S_FREE_WR) && out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = (t_func'(i_req_func) == FN_FREE) ? S_FREE_RD : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_ALLOC_WR;
                end
            end
            S_ALLOC_WR: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_FREE_RD: begin
                n_state = S_FREE_WR;
            end
            S_FREE_WR: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_rsp_valid = o_cmd.alloc_commit || o_cmd.free_commit ||
                      (r_rsp_valid && !i_rsp_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;

endmodule

### design/bfa_datapath.sv
module bfa_datapath #(
    parameter int HEAP_BYTES    = bfa_pkg::HEAP_BYTES_DEF,
    parameter int TABLE_ENTRIES = bfa_pkg::TABLE_ENTRIES_DEF,
    parameter int HEADER_BYTES  = bfa_pkg::HEADER_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bfa_pkg::t_cmd                i_cmd,
    output bfa_pkg::t_sts                o_sts,
    input  logic [bfa_pkg::SIZE_W-1:0]   i_request_size,
    input  logic [bfa_pkg::ADDR_W-1:0]   i_block_address,
    output logic [bfa_pkg::ADDR_W-1:0]   o_user_address,
    output logic [bfa_pkg::STATUS_W-1:0] o_status
);
    import bfa_pkg::*;

    localparam int IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW  = $clog2(TABLE_ENTRIES + 1);
    localparam int HAW = (HEAP_BYTES > 1) ? $clog2(HEAP_BYTES) : 1;
    localparam int EW  = 2 * ADDR_W;

    logic [SIZE_W-1:0] r_req_size;
    logic [ADDR_W-1:0] r_blk_addr;
    logic [CW-1:0]     r_idx;
    logic              r_rd_vld;
    logic [IW-1:0]     r_rd_idx;
    logic              r_found;
    logic [IW-1:0]     r_pick;
    logic [ADDR_W-1:0] r_best_base;
    logic [ADDR_W-1:0] r_best_len;
    logic [CW-1:0]     r_count;
    logic              r_e0_init;
    logic              r_hdr_ok;
    logic [ADDR_W-1:0] r_user_address;
    t_status           r_status;

    logic [ADDR_W:0]   total;
    logic [EW-1:0]     ext_rdata;
    logic [ADDR_W-1:0] cur_base;
    logic [ADDR_W-1:0] cur_len;
    logic              fit;
    logic [ADDR_W-1:0] free_start;
    logic              full;
    logic              more;

    logic              ext_we;
    logic [IW-1:0]     ext_waddr;
    logic [EW-1:0]     ext_wdata;
    logic              ext_re;
    logic              hdr_we;
    logic [ADDR_W-1:0] hdr_rdata;

    assign total      = {1'b0, r_req_size} + (ADDR_W+1)'(HEADER_BYTES);
    assign free_start = r_blk_addr - ADDR_W'(HEADER_BYTES);
    assign full       = (r_count >= CW'(TABLE_ENTRIES));
    assign more       = (r_idx < r_count);

    // entry 0 holds the whole heap until first written
    always_comb begin
        if ((r_rd_idx == '0) && r_e0_init) begin
            cur_base = '0;
            cur_len  = ADDR_W'(HEAP_BYTES);
        end else begin
            cur_base = ext_rdata[EW-1:ADDR_W];
            cur_len  = ext_rdata[ADDR_W-1:0];
        end
        fit = ({1'b0, cur_len} >= total) && (!r_found || (cur_len < r_best_len));
    end

    assign ext_re = i_cmd.scan && more;

    always_comb begin
        ext_we    = 1'b0;
        ext_waddr = r_pick;
        ext_wdata = {r_best_base + total[ADDR_W-1:0], r_best_len - total[ADDR_W-1:0]};
        if (i_cmd.alloc_commit && r_found) begin
            ext_we = 1'b1;
        end else if (i_cmd.free_commit && !full) begin
            ext_we    = 1'b1;
            ext_waddr = r_count[IW-1:0];
            ext_wdata = {free_start, (r_hdr_ok ? hdr_rdata : ADDR_W'(0))};
        end
    end

    assign hdr_we = i_cmd.alloc_commit && r_found && (r_best_base < ADDR_W'(HEAP_BYTES));

    bfa_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_ext_ram (
        .i_clk   (i_clk),
        .i_we    (ext_we),
        .i_waddr (ext_waddr),
        .i_wdata (ext_wdata),
        .i_re    (ext_re),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (ext_rdata)
    );

    bfa_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (HEAP_BYTES)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (hdr_we),
        .i_waddr (r_best_base[HAW-1:0]),
        .i_wdata (total[ADDR_W-1:0]),
        .i_re    (i_cmd.free_rd),
        .i_raddr (free_start[HAW-1:0]),
        .o_rdata (hdr_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= CW'(1);
            r_e0_init <= 1'b1;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_rd_vld <= ext_re;
            r_rd_idx <= r_idx[IW-1:0];
            if (ext_re) begin
                r_idx <= r_idx + CW'(1);
            end
            if (ext_we && (ext_waddr == '0)) begin
                r_e0_init <= 1'b0;
            end
            if (i_cmd.capture) begin
                r_req_size <= i_request_size;
                r_blk_addr <= i_block_address;
                r_idx      <= '0;
                r_found    <= 1'b0;
            end
            if (r_rd_vld && fit) begin
                r_found     <= 1'b1;
                r_pick      <= r_rd_idx;
                r_best_base <= cur_base;
                r_best_len  <= cur_len;
            end
            if (i_cmd.free_rd) begin
                r_hdr_ok <= (r_blk_addr >= ADDR_W'(HEADER_BYTES)) &&
                            (free_start < ADDR_W'(HEAP_BYTES));
            end
            if (i_cmd.alloc_commit) begin
                r_user_address <= r_found ? (r_best_base + ADDR_W'(HEADER_BYTES)) : '0;
                r_status       <= r_found ? ST_OK : ST_NOFIT;
            end
            if (i_cmd.free_commit) begin
                r_user_address <= '0;
                r_status       <= full ? ST_FULL : ST_OK;
                if (!full) begin
                    r_count <= r_count + CW'(1);
                end
            end
        end
    end

    assign o_sts.scan_done = !more && !r_rd_vld;
    assign o_user_address  = r_user_address;
    assign o_status        = r_status;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CW'(TABLE_ENTRIES)))
        else $error("extent count out of range");

    a_scan_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (CW'(r_rd_idx) < r_count))
        else $error("scan read beyond valid extents");

    a_full_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.free_commit && full) |=> ($stable(r_count) && (r_status == ST_FULL)))
        else $error("free into full table changed state");

    a_nofit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.alloc_commit && !r_found) |=>
        ((r_status == ST_NOFIT) && (r_user_address == '0)))
        else $error("failed allocate returned an address");

endmodule

### sim/tb_best_fit_block_allocator.sv
`timescale 1ns / 1ps

module tb_best_fit_block_allocator;
    import bfa_pkg::*;

    localparam int HEAP_N  = HEAP_BYTES_DEF;
    localparam int TABLE_N = TABLE_ENTRIES_DEF;
    localparam int HDR_N   = HEADER_BYTES_DEF;

    typedef struct packed {
        logic [ADDR_W-1:0] user_address;
        t_status           status;
    } t_alloc_result;

    class alloc_scoreboard;
        logic [ADDR_W-1:0] extent_start [TABLE_N];
        logic [SIZE_W-1:0] extent_bytes [TABLE_N];
        int                extent_total;
        logic [SIZE_W-1:0] block_size [HEAP_N];
        bit                size_written [HEAP_N];
        logic [ADDR_W-1:0] written_starts [$];
        logic [ADDR_W-1:0] live_blocks [$];
        t_alloc_result     awaited [$];
        int                error_count;

        function new();
            foreach (extent_start[i]) begin
                extent_start[i] = '0;
                extent_bytes[i] = '0;
            end
            foreach (block_size[i]) begin
                block_size[i]   = '0;
                size_written[i] = 1'b0;
            end
            extent_bytes[0] = SIZE_W'(HEAP_N);
            extent_total    = 1;
            error_count     = 0;
        endfunction

        // smallest extent that fits, lowest index on a tie
        function t_alloc_result carve_block(logic [SIZE_W-1:0] size);
            int                need;
            int                best;
            logic [ADDR_W-1:0] start;
            t_alloc_result     r;
            need           = int'(size) + HDR_N;
            best           = -1;
            r.user_address = '0;
            r.status       = ST_NOFIT;
            for (int i = 0; i < extent_total; i++) begin
                if (extent_bytes[i] >= need &&
                    (best < 0 || extent_bytes[i] < extent_bytes[best]))
                    best = i;
            end
            if (best >= 0) begin
                start = extent_start[best];
                if (start < HEAP_N) begin
                    if (!size_written[start])
                        written_starts.push_back(start);
                    size_written[start] = 1'b1;
                    block_size[start]   = SIZE_W'(need);
                    live_blocks.push_back(ADDR_W'(start + HDR_N));
                end
                extent_start[best] = ADDR_W'(start + need);
                extent_bytes[best] = SIZE_W'(extent_bytes[best] - need);
                r.user_address     = ADDR_W'(start + HDR_N);
                r.status           = ST_OK;
            end
            return r;
        endfunction

        // freed block becomes a new extent, no merging
        function t_alloc_result return_block(logic [ADDR_W-1:0] addr);
            logic [ADDR_W-1:0] start;
            t_alloc_result     r;
            start          = addr - ADDR_W'(HDR_N);
            r.user_address = '0;
            r.status       = ST_FULL;
            if (extent_total < TABLE_N) begin
                extent_start[extent_total] = start;
                extent_bytes[extent_total] =
                    (addr >= HDR_N && start < HEAP_N) ? block_size[start] : '0;
                extent_total++;
                r.status = ST_OK;
            end
            return r;
        endfunction

        function void note_request(t_func op, logic [SIZE_W-1:0] size,
                                   logic [ADDR_W-1:0] addr);
            if (op == FN_ALLOC)
                awaited.push_back(carve_block(size));
            else
                awaited.push_back(return_block(addr));
        endfunction

        task report_mismatch(string what, logic [ADDR_W-1:0] got,
                             logic [ADDR_W-1:0] want);
            $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
            error_count++;
        endtask

        task check_response(logic [ADDR_W-1:0] user_address, logic [STATUS_W-1:0] status);
            t_alloc_result e;
            if (awaited.size() == 0) begin
                report_mismatch("unexpected response", user_address, '0);
                return;
            end
            e = awaited.pop_front();
            if (user_address !== e.user_address)
                report_mismatch("user_address", user_address, e.user_address);
            if (status !== e.status)
                report_mismatch("status", ADDR_W'(status), ADDR_W'(e.status));
        endtask

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bfa_req_if req_bus ();
    bfa_rsp_if rsp_bus ();

    best_fit_block_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    alloc_scoreboard sb = new();

    int send_idle_pct;
    int recv_idle_pct;
    int rsp_hold_cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && req_bus.valid && req_bus.ready)
            sb.note_request(t_func'(req_bus.func), req_bus.request_size,
                            req_bus.block_address);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready)
            sb.check_response(rsp_bus.user_address, rsp_bus.status);
    end

    // response side, long hold-offs counted here
    initial begin
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_hold_cycles > 0) begin
                rsp_hold_cycles--;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic issue_request(t_func op, logic [SIZE_W-1:0] size,
                                 logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.func          <= op;
        req_bus.request_size  <= size;
        req_bus.block_address <= addr;
        @(posedge i_clk);
        while (!req_bus.ready)
            @(posedge i_clk);
    endtask

    task automatic wait_for_responses();
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic random_request();
        int                roll;
        int                idx;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        roll = $urandom_range(99);
        if (roll < 15) begin
            roll = $urandom_range(99);
            if (roll < 70 && sb.live_blocks.size() > 0) begin
                idx  = $urandom_range(sb.live_blocks.size() - 1);
                addr = sb.live_blocks[idx];
                sb.live_blocks.delete(idx);
            end else if (roll < 85 && sb.written_starts.size() > 0) begin
                idx  = $urandom_range(sb.written_starts.size() - 1);
                addr = ADDR_W'(sb.written_starts[idx] + HDR_N);
            end else if ($urandom_range(1) == 0) begin
                addr = ADDR_W'($urandom_range(HDR_N - 1));
            end else begin
                addr = ADDR_W'($urandom_range(255, HEAP_N + HDR_N));
            end
            issue_request(FN_FREE, SIZE_W'($urandom), addr);
        end else begin
            roll = $urandom_range(99);
            if (roll < 85)
                size = SIZE_W'($urandom_range(12));
            else if (roll < 95)
                size = SIZE_W'($urandom_range(HEAP_N, 13));
            else
                size = SIZE_W'($urandom_range(255, HEAP_N + 1));
            issue_request(FN_ALLOC, size, ADDR_W'($urandom));
        end
    endtask

    initial begin
        i_rst_n               <= 1'b0;
        req_bus.valid         <= 1'b0;
        req_bus.func          <= FN_ALLOC;
        req_bus.request_size  <= '0;
        req_bus.block_address <= '0;
        send_idle_pct   = 10;
        recv_idle_pct   = 77;
        rsp_hold_cycles = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // exact fits, oversize requests, double free, ties, headers outside the heap
        issue_request(FN_ALLOC, 8'd124, 8'd0);
        issue_request(FN_ALLOC, 8'd0,   8'd0);
        issue_request(FN_FREE,  8'd0,   8'd4);
        issue_request(FN_ALLOC, 8'd128, 8'd0);
        issue_request(FN_ALLOC, 8'd255, 8'd0);
        issue_request(FN_ALLOC, 8'd251, 8'd0);
        issue_request(FN_ALLOC, 8'd0,   8'd0);
        issue_request(FN_ALLOC, 8'd120, 8'd0);
        issue_request(FN_FREE,  8'd0,   8'd4);
        issue_request(FN_FREE,  8'd0,   8'd8);
        issue_request(FN_FREE,  8'd0,   8'd4);
        issue_request(FN_ALLOC, 8'd0,   8'd0);
        issue_request(FN_ALLOC, 8'd0,   8'd0);
        issue_request(FN_ALLOC, 8'd0,   8'd0);
        issue_request(FN_FREE,  8'd255, 8'd0);
        issue_request(FN_FREE,  8'd0,   8'd3);
        issue_request(FN_FREE,  8'd0,   8'd132);
        issue_request(FN_FREE,  8'd0,   8'd255);
        issue_request(FN_ALLOC, 8'd1,   8'd255);
        issue_request(FN_ALLOC, 8'd123, 8'd0);
        issue_request(FN_FREE,  8'd0,   8'd8);
        issue_request(FN_ALLOC, 8'd119, 8'd0);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 10;
                    recv_idle_pct = 77;
                end
                1: begin
                    send_idle_pct = 77;
                    recv_idle_pct = 10;
                end
                default: begin
                    send_idle_pct   = 0;
                    recv_idle_pct   = 0;
                    rsp_hold_cycles = 400;
                end
            endcase
            for (int n = 0; n < 510; n++) begin
                if (phase == 2 && n == 250)
                    wait_for_responses();
                random_request();
            end
        end

        wait_for_responses();
        repeat (100) @(posedge i_clk);
        if (sb.error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
